[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sparse 2:4 matrix-vector block.
// Assertions are clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define SP24_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SP24_ASSERT_IMPL(label, ante, cons, msg) \
  `SP24_ASSERT(label, (ante) |-> (cons), msg)

// Checks that a condition implies a consequence in the next cycle.
`define SP24_ASSERT_NEXT(label, ante, cons, msg) \
  `SP24_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/sp24_pkg.sv]
// ----------------------------------------------------------------------------
// sp24_pkg
// Types, constants and arithmetic helpers of the sparse 2:4 matrix-vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package sp24_pkg;

  localparam int unsigned MaxCols     = 1024;
  localparam int unsigned VecAddrW    = $clog2(MaxCols);
  localparam int unsigned RowCntBits  = 16;
  localparam int unsigned GrpCntW     = 8;
  localparam int unsigned CfgW        = 9;
  localparam int unsigned OffW        = 2;
  localparam logic [CfgW-1:0] GprReset = 9'd256;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_GROUP = 1'b1
  } req_e;

  typedef struct packed {
    logic               req_type;
    logic [9:0]         vec_index;
    logic signed [31:0] vec_value;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic [3:0]         meta_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] row_sum;
  } out_item_t;

  typedef struct packed {
    logic                  vld;
    logic                  grp;
    logic                  last;
    logic [RowCntBits-1:0] row;
  } ctl_t;

  typedef struct packed {
    logic [RowCntBits-1:0] row;
    logic signed [63:0]    sum;
  } fin_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] to_q16(logic signed [63:0] acc);
    logic signed [47:0] q;
    q = acc[63:16];
    if ((q[47:31] == '0) || (q[47:31] == '1)) begin
      return q[31:0];
    end
    return q[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

endpackage

`default_nettype wire

[rtl/sp24_vec_store.sv]
// ----------------------------------------------------------------------------
// sp24_vec_store
// Dense vector memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sp24_vec_store import sp24_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [VecAddrW-1:0] wr_addr_i,
  input  wire logic signed [31:0]  wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [VecAddrW-1:0] rd_addr0_i,
  input  wire logic [VecAddrW-1:0] rd_addr1_i,
  output logic signed [31:0]       rd_data0_o,
  output logic signed [31:0]       rd_data1_o
);

  logic signed [31:0] mem_q [MaxCols];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_o <= mem_q[rd_addr0_i];
      rd_data1_o <= mem_q[rd_addr1_i];
    end
  end

endmodule

`default_nettype wire

[rtl/sp24_mac.sv]
// ----------------------------------------------------------------------------
// sp24_mac
// Product stage and saturating row accumulator; finished row sums wait in a
// one-entry holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module sp24_mac import sp24_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire ctl_t               p1_ctl_i,
  input  wire logic signed [31:0] vf_i,
  input  wire logic signed [31:0] vs_i,
  input  wire logic signed [31:0] x0_i,
  input  wire logic signed [31:0] x1_i,
  input  wire logic               fin_take_i,
  output logic                    fin_vld_o,
  output fin_t                    fin_o
);

  ctl_t               p2_ctl_q;
  logic signed [63:0] prod0_q, prod1_q;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] acc_sum;
  logic               fin_vld_q, fin_vld_d;
  fin_t               fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_ctl_q <= '0;
    end else if (adv_i) begin
      p2_ctl_q <= p1_ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod0_q <= 64'(vf_i) * 64'(x0_i);
      prod1_q <= 64'(vs_i) * 64'(x1_i);
    end
  end

  assign acc_sum = sat_add64(sat_add64(acc_q, prod0_q), prod1_q);

  always_comb begin
    acc_d     = acc_q;
    fin_vld_d = fin_vld_q && !fin_take_i;
    if (adv_i && p2_ctl_q.vld) begin
      if (!p2_ctl_q.grp || p2_ctl_q.last) begin
        acc_d = '0;
      end else begin
        acc_d = acc_sum;
      end
      if (p2_ctl_q.grp && p2_ctl_q.last) begin
        fin_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      fin_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      fin_vld_q <= fin_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && p2_ctl_q.vld && p2_ctl_q.grp && p2_ctl_q.last) begin
      fin_q.row <= p2_ctl_q.row;
      fin_q.sum <= acc_sum;
    end
  end

  assign fin_vld_o = fin_vld_q;
  assign fin_o     = fin_q;

endmodule

`default_nettype wire

[rtl/sp24_out_stage.sv]
// ----------------------------------------------------------------------------
// sp24_out_stage
// Output register: truncates and saturates a row sum to Q16.16 and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sp24_out_stage import sp24_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fin_vld_i,
  input  wire fin_t  fin_i,
  output logic       fin_take_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output out_item_t  out_item_o
);

  logic      out_vld_q, out_vld_d;
  out_item_t out_q;

  assign fin_take_o = fin_vld_i && (!out_vld_q || !out_stall_i);

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (fin_take_o) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take_o) begin
      out_q.row_index <= fin_i.row[15:0];
      out_q.row_sum   <= to_q16(fin_i.sum);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[rtl/sparse_2_4_matrix_vector.sv]
// A group item that ends a row passes the input, product and row-sum holding registers.
// One item per cycle while not stalled; the vector memory's two read ports serve a group.
// Input stalls only while both the output register and the row-sum holding
// register are full and the output is stalled.
// Reset clears the counters, the accumulator and groups_per_row (to 256); the
// vector memory is not cleared.
// ----------------------------------------------------------------------------
// sparse_2_4_matrix_vector
// Streaming matrix-vector product for a matrix in 2:4 structured sparsity.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_2_4_matrix_vector import sp24_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_item_t            out_item_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0]       gpr_q;
  logic [GrpCntW-1:0]    grp_cnt_q, last_grp;
  logic [RowCntBits-1:0] row_cnt_q;
  logic                  adv, accept, is_grp, is_last;
  logic                  fin_vld, fin_take;
  fin_t                  fin;
  ctl_t                  p1_ctl_q;
  logic signed [31:0]    vf_q, vs_q, x0, x1;
  logic [VecAddrW-1:0]   rd_addr0, rd_addr1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_q <= GprReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gpr_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (gpr_q == '0) begin
      last_grp = '0;
    end else if (gpr_q[CfgW-1]) begin
      last_grp = '1;
    end else begin
      last_grp = gpr_q[GrpCntW-1:0] - GrpCntW'(1);
    end
  end

  assign adv        = !fin_vld || fin_take;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign is_grp     = (in_item_i.req_type == REQ_GROUP);
  assign is_last    = (grp_cnt_q >= last_grp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (!is_grp) begin
        grp_cnt_q <= '0;
        row_cnt_q <= '0;
      end else if (is_last) begin
        grp_cnt_q <= '0;
        row_cnt_q <= row_cnt_q + RowCntBits'(1);
      end else begin
        grp_cnt_q <= grp_cnt_q + GrpCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q <= '0;
    end else if (adv) begin
      p1_ctl_q.vld  <= accept;
      p1_ctl_q.grp  <= is_grp;
      p1_ctl_q.last <= is_last;
      p1_ctl_q.row  <= row_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vf_q <= in_item_i.value_first;
      vs_q <= in_item_i.value_second;
    end
  end

  assign rd_addr0 = VecAddrW'({grp_cnt_q, in_item_i.meta_bits[OffW-1:0]});
  assign rd_addr1 = VecAddrW'({grp_cnt_q, in_item_i.meta_bits[2*OffW-1:OffW]});

  sp24_vec_store u_vec_store (
    .clk_i      (clk_i),
    .wr_en_i    (accept && !is_grp),
    .wr_addr_i  (VecAddrW'(in_item_i.vec_index)),
    .wr_data_i  (in_item_i.vec_value),
    .rd_en_i    (accept && is_grp),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .rd_data0_o (x0),
    .rd_data1_o (x1)
  );

  sp24_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .p1_ctl_i   (p1_ctl_q),
    .vf_i       (vf_q),
    .vs_i       (vs_q),
    .x0_i       (x0),
    .x1_i       (x1),
    .fin_take_i (fin_take),
    .fin_vld_o  (fin_vld),
    .fin_o      (fin)
  );

  sp24_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_vld_i   (fin_vld),
    .fin_i       (fin),
    .fin_take_o  (fin_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[rtl/sp24_checker.sv]
// ----------------------------------------------------------------------------
// sp24_checker
// Port-level assertions for the sparse 2:4 matrix-vector block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sp24_checker import sp24_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire out_item_t       out_item_o
);

  // A stalled result must stay on the port unchanged.
  `SP24_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_item_o), "stalled result changed")

  // The input side only stalls when the output side is blocked.
  `SP24_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                    "input stalled without a blocked output")

  // An input stall means a result is held and is still offered next cycle.
  `SP24_ASSERT_NEXT(a_stall_result, in_stall_o, out_valid_o,
                    "input stalled but no result followed")

endmodule

bind sparse_2_4_matrix_vector sp24_checker u_checker (.*);

`default_nettype wire
